>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion forms for the speed meter top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/ppsm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse period speed meter package
// Widths, reset values, register map codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppsm_pkg;

  // Counter and field widths.
  localparam int CNT_W      = 16;
  localparam int OVF_W      = 8;
  localparam int PERIOD_W   = CNT_W + OVF_W;
  localparam int DIVIDEND_W = 24;
  localparam int LIMIT_W    = 8;
  localparam int TRIM_W     = 4;
  localparam int SPEED_W    = 16;

  // The divider covers both the dividend and the period.
  localparam int DIV_W      = (PERIOD_W > DIVIDEND_W) ? PERIOD_W : DIVIDEND_W;
  localparam int DIV_STEP_W = $clog2(DIV_W + 1);

  // Register reset values.
  localparam logic [DIVIDEND_W-1:0] DIVIDEND_RESET = DIVIDEND_W'(1724138);
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = LIMIT_W'(64);
  localparam logic [TRIM_W-1:0]     TRIM_RESET     = TRIM_W'(2);

  // Register map.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_SPEED_DIVIDEND = 2'd0;
  localparam logic [1:0] REG_OVERFLOW_LIMIT = 2'd1;
  localparam logic [1:0] REG_LATENCY_TRIM   = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PUBLISH
  } ppsm_state_e;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } ppsm_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ppsm_div_stat_t;

endpackage

>>> rtl/ppsm_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsm_div
  import ppsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppsm_div_ctrl_t       ctrl_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [DIV_W-1:0]     divisor_i,
  output ppsm_div_stat_t       stat_o,
  output logic [DIV_W-1:0]     quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] count_q, count_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      quot_q, quot_d;
  logic [DIV_W-1:0]      divisor_q, divisor_d;
  logic [DIV_W:0]        shifted;
  logic [DIV_W+1:0]      trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quot_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    count_d   = count_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    divisor_d = divisor_q;
    if (ctrl_i.start) begin
      busy_d    = 1'b1;
      count_d   = DIV_STEP_W'(DIV_W);
      rem_d     = '0;
      quot_d    = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      if (!trial[DIV_W+1]) begin
        rem_d  = trial[DIV_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DIV_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b0};
      end
      count_d = count_q - DIV_STEP_W'(1);
      if (count_q == DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    divisor_q <= divisor_d;
  end

  // A zero divisor yields an all-ones quotient, which saturates upstream.
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quot_q;

endmodule

>>> rtl/pulse_period_speed_meter.sv
// ----------------------------------------------------------------------------
// Pulse period speed meter
// Measures the period between sensor edges and reports speed as a reciprocal.
// ----------------------------------------------------------------------------
// Each input transaction may carry a timebase tick, a sensor edge and a
// report request, handled in that order. A transaction that needs no new
// speed value goes through the publish state to the output register. One
// whose request refreshes the speed of a running sensor first waits in the
// divide state for the serial divider, which resolves one of 24 quotient bits
// per cycle. The block accepts one transaction at a time; the output register
// lets the next one start while an earlier result still waits to be taken.
`timescale 1ns / 1ps

module pulse_period_speed_meter
  import ppsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  tick_i,
  input  logic                  sensor_edge_i,
  input  logic                  report_request_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SPEED_W-1:0]    speed_tenths_o,
  output logic                  stopped_o,
  output logic                  recomputed_o
);

`include "assert_macros.svh"

  // Configuration registers.
  logic [DIVIDEND_W-1:0] speed_dividend_q;
  logic [LIMIT_W-1:0]    overflow_limit_q;
  logic [TRIM_W-1:0]     latency_trim_q;
  logic                  cfg_write;

  // Sequencer.
  ppsm_state_e state_q, state_d;
  logic        accept;
  logic        out_free;
  logic        publish;
  logic        need_div;

  // Measurement state.
  logic [CNT_W-1:0]    tick_count_q, tick_count_d;
  logic [OVF_W-1:0]    overflow_count_q, overflow_count_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                armed_q, armed_d;
  logic                stopped_q, stopped_d;
  logic                changed_q, changed_d;
  logic [SPEED_W-1:0]  speed_q, speed_d;
  logic                refreshed_q, refreshed_d;

  // Per-transaction intermediate values.
  logic [CNT_W-1:0] tc_step;
  logic             wrap;
  logic             limit_hit;
  logic [OVF_W-1:0] ovf_step;
  logic             stop_step;
  logic             armed_step;
  logic             chg_step;
  logic [CNT_W-1:0] low_part;
  logic             capture;
  logic             stop_after;
  logic             chg_after;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [SPEED_W-1:0] out_speed_q;
  logic               out_stopped_q;
  logic               out_recomputed_q;

  // Divider.
  ppsm_div_ctrl_t     div_ctrl;
  ppsm_div_stat_t     div_stat;
  logic [DIV_W-1:0]   quotient;
  logic [SPEED_W-1:0] speed_sat;

  // Register write and read.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_dividend_q <= DIVIDEND_RESET;
      overflow_limit_q <= LIMIT_RESET;
      latency_trim_q   <= TRIM_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SPEED_DIVIDEND: speed_dividend_q <= pwdata[DIVIDEND_W-1:0];
        REG_OVERFLOW_LIMIT: overflow_limit_q <= pwdata[LIMIT_W-1:0];
        REG_LATENCY_TRIM:   latency_trim_q   <= pwdata[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SPEED_DIVIDEND: prdata = APB_DATA_W'(speed_dividend_q);
      REG_OVERFLOW_LIMIT: prdata = APB_DATA_W'(overflow_limit_q);
      REG_LATENCY_TRIM:   prdata = APB_DATA_W'(latency_trim_q);
      default:            prdata = '0;
    endcase
  end

  // Tick, edge and request effects of the transaction on offer.
  always_comb begin
    tc_step    = tick_i ? tick_count_q + CNT_W'(1) : tick_count_q;
    wrap       = tick_i && (tc_step == '0);
    limit_hit  = wrap && (overflow_count_q >= overflow_limit_q);
    ovf_step   = (wrap && !limit_hit) ? overflow_count_q + OVF_W'(1) : overflow_count_q;
    stop_step  = stopped_q || limit_hit;
    armed_step = armed_q && !limit_hit;
    chg_step   = changed_q || limit_hit;
    low_part   = tc_step - CNT_W'(latency_trim_q);
    capture    = sensor_edge_i && armed_step;
    stop_after = capture ? 1'b0 : stop_step;
    chg_after  = capture || chg_step;
    need_div   = report_request_i && chg_after && !stop_after;
  end

  // Saturate the quotient to the speed width.
  assign speed_sat = (|quotient[DIV_W-1:SPEED_W]) ? '1 : quotient[SPEED_W-1:0];

  // Next measurement state.
  always_comb begin
    tick_count_d     = tick_count_q;
    overflow_count_d = overflow_count_q;
    period_d         = period_q;
    armed_d          = armed_q;
    stopped_d        = stopped_q;
    changed_d        = changed_q;
    speed_d          = speed_q;
    refreshed_d      = refreshed_q;
    if (accept) begin
      tick_count_d     = sensor_edge_i ? '0 : tc_step;
      overflow_count_d = sensor_edge_i ? '0 : ovf_step;
      armed_d          = sensor_edge_i || armed_step;
      stopped_d        = stop_after;
      changed_d        = chg_after;
      refreshed_d      = 1'b0;
      if (capture) begin
        period_d = {ovf_step, low_part};
      end
      if (report_request_i && chg_after) begin
        changed_d   = 1'b0;
        refreshed_d = 1'b1;
        if (stop_after) begin
          speed_d = '0;
        end
      end
    end else if (div_stat.done) begin
      speed_d = speed_sat;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = need_div ? ST_DIVIDE : ST_PUBLISH;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    publish        = 1'b0;
    div_ctrl.start = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_DIVIDE:  ;
      ST_PUBLISH: publish = out_free;
      default:    ;
    endcase
    accept         = in_valid_i && in_ready_o;
    div_ctrl.start = accept && need_div;
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = publish || (out_valid_q && !out_ready_i);

  // Control and measurement state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      tick_count_q     <= '0;
      overflow_count_q <= '0;
      period_q         <= '0;
      armed_q          <= 1'b0;
      stopped_q        <= 1'b1;
      changed_q        <= 1'b1;
      speed_q          <= '0;
      refreshed_q      <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      tick_count_q     <= tick_count_d;
      overflow_count_q <= overflow_count_d;
      period_q         <= period_d;
      armed_q          <= armed_d;
      stopped_q        <= stopped_d;
      changed_q        <= changed_d;
      speed_q          <= speed_d;
      refreshed_q      <= refreshed_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // Result payload is loaded when the result is handed to the output register.
  always_ff @(posedge clk_i) begin
    if (publish) begin
      out_speed_q      <= speed_q;
      out_stopped_q    <= stopped_q;
      out_recomputed_q <= refreshed_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign speed_tenths_o = out_speed_q;
  assign stopped_o      = out_stopped_q;
  assign recomputed_o   = out_recomputed_q;

  // Divider for the reciprocal.
  ppsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (DIV_W'(speed_dividend_q)),
    .divisor_i  (DIV_W'(period_d)),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // A new transaction is never taken while the divider is still working.
  `ASSERT_IMPLIES(a_ready_not_busy, clk_i, rst_ni, in_ready_o, !div_stat.busy)
  // Divider completion only arrives while the sequencer waits for it.
  `ASSERT_IMPLIES(a_done_in_divide, clk_i, rst_ni, div_stat.done, state_q == ST_DIVIDE)
  // Acceptance always leaves the input side blocked in the following cycle.
  `ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, accept, !in_ready_o)
  // A stopped sensor always reports zero speed once refreshed.
  `ASSERT_IMPLIES(a_stopped_zero, clk_i, rst_ni,
    out_valid_o && recomputed_o && stopped_o, speed_tenths_o == '0)

endmodule
